FILE: design/ulpd_pkg.sv
// shared types and constants for the url percent decoder
package ulpd_pkg;

  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  // one byte after classification
  typedef struct packed {
    logic [7:0] raw;
    logic       last;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_pct;
    logic       is_plus;
  } cls_t;

endpackage

FILE: design/ulpd_front.sv
// front stage: accepts raw bytes, classifies them and registers the result
module ulpd_front
  import ulpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       cls_valid,
  input  logic       cls_ready,
  output cls_t       cls_data
);

  cls_t cls_next;

  always_comb begin
    cls_next         = '0;
    cls_next.raw     = in_byte;
    cls_next.last    = in_last;
    cls_next.is_pct  = (in_byte == CH_PERCENT);
    cls_next.is_plus = (in_byte == CH_PLUS);
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      cls_next.is_hex  = 1'b1;
      cls_next.hex_val = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      cls_next.is_hex  = 1'b1;
      cls_next.hex_val = 4'(in_byte[2:0] + 3'd1) + 4'd8;
    end
  end

  assign in_ready = !cls_valid || cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (in_ready) begin
      cls_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls_data <= cls_next;
    end
  end

endmodule

FILE: design/ulpd_queue.sv
// two-entry queue between the classifier and the escape tracker
module ulpd_queue
  import ulpd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cls_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cls_t pop_data
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cls_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(do_push) - CntW'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_pop)
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

FILE: design/ulpd_back.sv
// back stage: escape tracker and output register
module ulpd_back
  import ulpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cls_valid,
  output logic       cls_ready,
  input  cls_t       cls_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [1:0] phase;
  logic [3:0] high_nibble;
  logic       high_valid;
  logic [1:0] phase_next;
  logic [3:0] high_nibble_next;
  logic       high_valid_next;
  logic       emit;
  logic [7:0] res;
  logic       pop;

  always_comb begin
    phase_next       = PH_IDLE;
    high_nibble_next = high_nibble;
    high_valid_next  = high_valid;
    emit             = 1'b0;
    res              = '0;
    case (phase)
      PH_FIRST: begin
        high_valid_next  = cls_data.is_hex;
        high_nibble_next = cls_data.is_hex ? cls_data.hex_val : 4'd0;
        phase_next       = PH_SECOND;
        emit             = cls_data.last;
        res              = {4'd0, high_nibble_next};
      end
      PH_SECOND: begin
        emit = 1'b1;
        if (!high_valid) begin
          res = '0;
        end else if (cls_data.is_hex) begin
          res = {high_nibble, cls_data.hex_val};
        end else begin
          res = {4'd0, high_nibble};
        end
      end
      default: begin
        if (cls_data.is_pct) begin
          phase_next       = PH_FIRST;
          high_valid_next  = 1'b0;
          high_nibble_next = '0;
          emit             = cls_data.last;
        end else begin
          emit = 1'b1;
          res  = cls_data.is_plus ? CH_SPACE : cls_data.raw;
        end
      end
    endcase
    // end of string puts the tracker back to its reset state
    if (cls_data.last) begin
      phase_next       = PH_IDLE;
      high_valid_next  = 1'b0;
      high_nibble_next = '0;
    end
  end

  assign cls_ready = !emit || !out_valid || out_ready;
  assign pop       = cls_valid && cls_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      high_nibble <= '0;
      high_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        phase       <= phase_next;
        high_nibble <= high_nibble_next;
        high_valid  <= high_valid_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_byte <= res;
      out_last <= cls_data.last;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (pop && cls_data.last) |=> (phase == PH_IDLE && !high_valid))
    else $error("tracker not idle after end of string");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    (pop && emit) |=> out_valid)
    else $error("emitted beat did not reach output");

  a_bad_escape_zero: assert property (@(posedge clk) disable iff (rst)
    (pop && phase == PH_SECOND && !high_valid) |=> (out_byte == 8'd0))
    else $error("escape without leading digit gave nonzero byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(pop && emit))
    else $error("output beat overwritten while stalled");

endmodule

FILE: design/url_percent_decoder.sv
// url percent decoder top level: classifier, queue and escape tracker
// a result passes the front register, a queue entry and the output register after its last input byte is accepted
// throughput: one input byte per cycle while the output is not stalled, set by the escape tracker
// a % and the digit after it emit no beat unless last, and pass the tracker even while output stalls
// rst is synchronous: clears the queue, the escape state and all valid flags
// after reset the block is idle and takes a new string at once
module url_percent_decoder
  import ulpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  // classified beat leaving the front register
  logic f_valid;
  logic f_ready;
  cls_t f_data;

  // head of the queue feeding the tracker
  logic q_valid;
  logic q_ready;
  cls_t q_data;

  // front: accepts a byte and decodes hex digit, percent and plus flags
  ulpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cls_valid (f_valid),
    .cls_ready (f_ready),
    .cls_data  (f_data)
  );

  // short queue so the front keeps taking bytes while the output is stalled, until the queue is full
  ulpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // back: three-phase escape tracker and registered output
  ulpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (q_valid),
    .cls_ready (q_ready),
    .cls_data  (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
